[sv/fstg_pkg.sv]
package fstg_pkg;

	localparam int SAMPLE_RATE_DEF      = 48000;
	localparam int SINE_TABLE_DEPTH_DEF = 1024;

	localparam int FREQ_W  = 16;
	localparam int DUR_W   = 14;
	localparam int SMP_W   = 16;
	localparam int PHASE_W = 32;
	localparam int LEN_W   = 19;
	localparam int FADE_W  = 8;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam int FADE_LONG = 200;
	localparam int FADE_KNEE = 400;
	localparam int MS_PER_S  = 1000;

	// sine table word, its magnitude, magnitude times 32767, envelope fraction
	localparam int TBL_W      = 16;
	localparam int MAG_W      = 15;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int ENV_FRAC_W = 16;
	localparam int ACC_W      = PROD_W + ENV_FRAC_W;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t          command;
		logic [FREQ_W-1:0]  freq_hz;
		logic [DUR_W-1:0]   dur_ms;
	} cmd_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_value;
		logic                    segment_active;
		logic                    last_sample;
	} smp_t;

	typedef struct packed {
		logic               start;
		logic               full;
		logic [FADE_W-1:0]  num;
		logic [FADE_W-1:0]  fade;
		logic [PROD_W-1:0]  prod;
	} env_req_t;

endpackage

[sv/faded_sine_tone_generator_top.sv]
// Sine tone segment generator. A start beat (command 0) loads a segment of
// SAMPLE_RATE*dur_ms/1000 samples at freq_hz and restarts the phase; it
// returns no beat, and its work is two 48-step runs of the shared bit-serial
// divider (segment length, then phase increment). A tick beat (command 1)
// returns one sample beat: for a running tone it goes through the registered
// sine table read and the serial envelope divide/multiply, and when idle or
// silent it goes straight to the output write. One beat is worked on
// at a time; a finished sample waits in the output register while the next
// beat is taken. Frequency 0 gives a silent segment; a start that yields zero
// samples is dropped and leaves the current segment running. No init sweep.
module faded_sine_tone_generator_top import fstg_pkg::*; #(
	parameter int SAMPLE_RATE      = SAMPLE_RATE_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd_data,
	output logic sample_valid,
	input  logic sample_stall,
	output smp_t sample_data
);

	localparam int AW      = $clog2(SINE_TABLE_DEPTH);
	localparam int SR_W    = $clog2(SAMPLE_RATE + 1);
	localparam int DVD_W   = FREQ_W + PHASE_W;
	localparam int LPROD_W = SR_W + DUR_W;
	localparam int PMUL_W  = PHASE_W + AW + 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LEN  = 7'b0000010,
		ST_STEP = 7'b0000100,
		ST_RD   = 7'b0001000,
		ST_LD   = 7'b0010000,
		ST_MUL  = 7'b0100000,
		ST_WR   = 7'b1000000
	} state_t;

	state_t state_q;

	// segment state
	logic               running_q;
	logic               silent_q;
	logic [LEN_W-1:0]   seg_len_q;
	logic [FADE_W-1:0]  fade_q;
	logic [PHASE_W-1:0] step_q;
	logic [PHASE_W-1:0] phase_q;
	logic [LEN_W-1:0]   idx_q;

	logic [FREQ_W-1:0]  freq_q;
	logic [LEN_W-1:0]   pend_len_q;
	logic [AW-1:0]      addr_q;
	logic               env_full_q;
	logic [FADE_W-1:0]  env_num_q;
	logic               res_zero_q;
	logic               res_active_q;
	logic               res_last_q;
	logic               neg_q;
	logic               smp_valid_q;
	smp_t               smp_q;

	logic               cmd_acc;
	logic               is_start;
	logic               slot_free;

	logic [LPROD_W-1:0] len_prod;
	logic [DVD_W-1:0]   step_dvd;
	logic               div_start;
	logic [DVD_W-1:0]   div_dvd;
	logic [SR_W-1:0]    div_dsr;
	logic               div_busy;
	logic [DVD_W-1:0]   div_quot;
	logic [LEN_W-1:0]   len_sat;

	logic [LEN_W-1:0]   fade_ext;
	logic               in_head;
	logic               in_tail;
	logic [LEN_W-1:0]   idx_nxt;
	logic               last_nxt;
	logic [LEN_W-1:0]   rem_len;
	logic [PMUL_W-1:0]  phase_mul;
	logic [AW-1:0]      addr_nxt;

	logic signed [TBL_W-1:0] rom_data;
	logic [MAG_W-1:0]        s_abs;
	env_req_t                env_req;
	logic                    env_busy;
	logic [MAG_W-1:0]        env_mag;
	logic signed [SMP_W-1:0] mag_s;
	logic signed [SMP_W-1:0] sample_nxt;

	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign is_start  = cmd_data.command == CMD_START;
	assign cmd_stall = state_q != ST_IDLE;
	assign slot_free = !smp_valid_q || !sample_stall;

	// start: length = rate*ms/1000, then increment = (f*2^32 + rate/2)/rate
	assign len_prod  = LPROD_W'(SAMPLE_RATE) * LPROD_W'(cmd_data.dur_ms);
	assign step_dvd  = {freq_q, PHASE_W'(0)} + DVD_W'(SAMPLE_RATE / 2);
	assign div_start = (cmd_acc && is_start) ||
	                   (state_q == ST_LEN && !div_busy && (div_quot != '0));
	assign div_dvd   = (state_q == ST_IDLE) ? DVD_W'(len_prod) : step_dvd;
	assign div_dsr   = (state_q == ST_IDLE) ? SR_W'(MS_PER_S) : SR_W'(SAMPLE_RATE);
	assign len_sat   = (div_quot[DVD_W-1:LEN_W] != '0) ? LEN_MAX : div_quot[LEN_W-1:0];

	fstg_sdiv #(
		.DW(DVD_W),
		.VW(SR_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dsr),
		.busy    (div_busy),
		.quotient(div_quot)
	);

	// tick: envelope region and table address from the current index/phase
	assign fade_ext  = LEN_W'(fade_q);
	assign in_head   = idx_q < fade_ext;
	assign in_tail   = idx_q > (seg_len_q - fade_ext);
	assign idx_nxt   = idx_q + LEN_W'(1);
	assign last_nxt  = idx_nxt >= seg_len_q;
	assign rem_len   = seg_len_q - idx_q;
	assign phase_mul = PMUL_W'(phase_q) * PMUL_W'(SINE_TABLE_DEPTH);
	assign addr_nxt  = phase_mul[PHASE_W +: AW];

	fstg_rom #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_rom (
		.clk (clk),
		.addr(addr_q),
		.data(rom_data)
	);

	// |s| * 32767 as a shift and subtract
	assign s_abs         = rom_data[TBL_W-1] ? MAG_W'(-rom_data) : rom_data[MAG_W-1:0];
	assign env_req.start = state_q == ST_LD;
	assign env_req.full  = env_full_q;
	assign env_req.num   = env_num_q;
	assign env_req.fade  = fade_q;
	assign env_req.prod  = {s_abs, MAG_W'(0)} - PROD_W'(s_abs);

	fstg_env u_env (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (env_req),
		.busy  (env_busy),
		.mag   (env_mag)
	);

	assign mag_s      = {{(SMP_W - MAG_W){1'b0}}, env_mag};
	assign sample_nxt = res_zero_q ? '0 : (neg_q ? -mag_s : mag_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			silent_q    <= 1'b0;
			seg_len_q   <= '0;
			fade_q      <= '0;
			step_q      <= '0;
			phase_q     <= '0;
			idx_q       <= '0;
			smp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_WR && slot_free)
				smp_valid_q <= 1'b1;
			else if (!sample_stall)
				smp_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						if (is_start)
							state_q <= ST_LEN;
						else if (!running_q || silent_q)
							state_q <= ST_WR;
						else
							state_q <= ST_RD;
						if (!is_start && running_q) begin
							phase_q <= phase_q + step_q;
							idx_q   <= idx_nxt;
							if (last_nxt)
								running_q <= 1'b0;
						end
					end
				end
				ST_LEN: begin
					if (!div_busy)
						state_q <= (div_quot != '0) ? ST_STEP : ST_IDLE;
				end
				ST_STEP: begin
					if (!div_busy) begin
						seg_len_q <= pend_len_q;
						fade_q    <= (pend_len_q > LEN_W'(FADE_KNEE)) ?
						             FADE_W'(FADE_LONG) : FADE_W'(pend_len_q >> 2);
						silent_q  <= freq_q == '0;
						step_q    <= div_quot[PHASE_W-1:0];
						phase_q   <= '0;
						idx_q     <= '0;
						running_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_RD:  state_q <= ST_LD;
				ST_LD:  state_q <= ST_MUL;
				ST_MUL: begin
					if (!env_busy)
						state_q <= ST_WR;
				end
				ST_WR: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc && is_start)
			freq_q <= cmd_data.freq_hz;
		if (cmd_acc) begin
			addr_q       <= addr_nxt;
			env_full_q   <= (fade_q == '0) || (!in_head && !in_tail);
			env_num_q    <= in_head ? FADE_W'(idx_q) : FADE_W'(rem_len);
			res_zero_q   <= !running_q || silent_q;
			res_active_q <= running_q;
			res_last_q   <= running_q && last_nxt;
		end
		if (state_q == ST_LEN && !div_busy)
			pend_len_q <= len_sat;
		if (state_q == ST_LD)
			neg_q <= rom_data[TBL_W-1];
		if (state_q == ST_WR && slot_free) begin
			smp_q.sample_value   <= sample_nxt;
			smp_q.segment_active <= res_active_q;
			smp_q.last_sample    <= res_last_q;
		end
	end

	assign sample_valid = smp_valid_q;
	assign sample_data  = smp_q;

endmodule

[sv/fstg_sdiv.sv]
// Restoring divider, one quotient bit per cycle.
module fstg_sdiv #(
	parameter int DW = 48,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW);

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], fits};
			rem_q <= fits ? VW'(trial - {1'b0, dsr_q}) : trial[VW-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

[sv/fstg_rom.sv]
module fstg_rom import fstg_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	localparam int AW = $clog2(SINE_TABLE_DEPTH)
) (
	input  logic                    clk,
	input  logic [AW-1:0]           addr,
	output logic signed [TBL_W-1:0] data
);

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

	typedef logic signed [TBL_W-1:0] rom_t [SINE_TABLE_DEPTH];

	// round(32768*sin), Taylor series in Q30; a is the angle in 2^-32 turns
	function automatic logic signed [TBL_W-1:0] sine_entry(input logic [63:0] a);
		logic [1:0]              quad;
		logic [63:0]             r;
		logic [63:0]             x;
		logic [63:0]             x2;
		logic [63:0]             term;
		logic signed [63:0]      sum;
		logic [63:0]             v;
		logic signed [TBL_W-1:0] mag;
		quad = a[31:30];
		r    = {34'd0, a[29:0]};
		if (quad[0])
			r = Q30_ONE - r;
		x    = (r * Q30_HALF_PI) >> 30;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 156;
		sum  = sum + $signed(term);
		if (sum < 0)
			sum = '0;
		v = ($unsigned(sum) + 64'd16384) >> 15;
		if (v > 64'd32767)
			v = 64'd32767;
		mag = TBL_W'(v);
		return quad[1] ? -mag : mag;
	endfunction

	function automatic rom_t build_rom();
		rom_t t;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++)
			t[i] = sine_entry((64'(i) << 32) / SINE_TABLE_DEPTH);
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	logic signed [TBL_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= ROM[addr];
	end

	assign data = data_q;

endmodule

[sv/fstg_env.sv]
// Envelope divide and scale, one bit per cycle: the fade quotient comes out
// MSB first and is folded straight into a shift-add multiply.
module fstg_env import fstg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  env_req_t         req,
	output logic             busy,
	output logic [MAG_W-1:0] mag
);

	localparam int CW = $clog2(ENV_FRAC_W);

	logic              busy_q;
	logic [CW-1:0]     cnt_q;
	logic              full_q;
	logic [FADE_W-1:0] fade_q;
	logic [FADE_W-1:0] rem_q;
	logic [PROD_W-1:0] p_q;
	logic [ACC_W-1:0]  acc_q;
	logic [FADE_W:0]   trial;
	logic              take;

	assign trial = {rem_q, 1'b0};
	assign take  = !full_q && (trial >= {1'b0, fade_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ENV_FRAC_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// full scale: preload the product, the shifts make it p * 2^16
	always_ff @(posedge clk) begin
		if (req.start) begin
			full_q <= req.full;
			fade_q <= req.fade;
			rem_q  <= req.num;
			p_q    <= req.prod;
			acc_q  <= req.full ? ACC_W'(req.prod) : '0;
		end else if (busy_q) begin
			rem_q <= take ? FADE_W'(trial - {1'b0, fade_q}) : trial[FADE_W-1:0];
			acc_q <= {acc_q[ACC_W-2:0], 1'b0} + (take ? ACC_W'(p_q) : '0);
		end
	end

	assign busy = busy_q;
	assign mag  = acc_q[ACC_W-1 -: MAG_W];

endmodule

[sv/fstg_chk.sv]
module fstg_chk import fstg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd_data,
	input logic sample_valid,
	input logic sample_stall,
	input smp_t sample_data
);

	logic       tick_acc;
	logic       smp_acc;
	logic [1:0] pend_q;

	assign tick_acc = cmd_valid && !cmd_stall && (cmd_data.command == CMD_TICK);
	assign smp_acc  = sample_valid && !sample_stall;

	// ticks taken whose sample beat has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (tick_acc && !smp_acc)
			pend_q <= pend_q + 2'd1;
		else if (!tick_acc && smp_acc)
			pend_q <= pend_q - 2'd1;
	end

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while previous beat still in work");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> pend_q != 2'd0)
		else $error("sample beat without an outstanding tick");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_data.segment_active |->
			sample_data.sample_value == '0 && !sample_data.last_sample)
		else $error("idle sample not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(sample_data))
		else $error("stalled sample beat changed");

endmodule

bind faded_sine_tone_generator_top fstg_chk u_fstg_chk (.*);
